// ===== rtl/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the four-operation float ALU.
// Holds the transaction structs, the opcode codes and the pipeline sizes.
// ----------------------------------------------------------------------------
package fpa_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } fpa_op_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        divide_by_zero;
  } fpa_out_t;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

  // Quotient bits developed: 24 mantissa bits, one extra for normalization,
  // one guard bit. One radix-2 step per pipeline stage.
  localparam int QBITS = 26;

  // Unpacked operand with the class of the value decoded.
  typedef struct packed {
    logic        sgn;
    logic signed [10:0] exp;   // unbiased, subnormals normalized
    logic [23:0] man;          // leading one at bit 23
    logic        zero;
    logic        inf;
    logic        nan;
  } fpa_unp_t;

  // Intermediate result before rounding. The value is
  // man * 2^(exp - 26); man has its leading one at bit 27 or below, plus sticky.
  typedef struct packed {
    logic        sgn;
    logic signed [11:0] exp;
    logic [27:0] man;
    logic        sticky;
    logic        special;
    logic [31:0] special_bits;
    logic        dz;
  } fpa_raw_t;

  // Count leading zeros of a 28-bit vector.
  function automatic logic [4:0] clz28(input logic [27:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd28;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(27 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Unpack a binary32 pattern, normalizing subnormals.
  function automatic fpa_unp_t unpack(input logic [31:0] b);
    fpa_unp_t u;
    logic [4:0] lz;
    u.sgn  = b[31];
    u.zero = (b[30:0] == 31'd0);
    u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    lz     = clz28({b[22:0], 5'd0});
    if (b[30:23] == 8'd0) begin
      u.man = 24'({1'b0, b[22:0]} << (lz + 5'd1));
      u.exp = -11'sd127 - 11'(lz);
    end else begin
      u.man = {1'b1, b[22:0]};
      u.exp = 11'(b[30:23]) - 11'sd127;
    end
    return u;
  endfunction

endpackage

// ===== rtl/float_four_op_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_four_op_alu: binary32 add, subtract, multiply and divide.
// Pipelined unit taking one transaction per cycle while in_ready is high.
// ----------------------------------------------------------------------------
// Each transaction carries an opcode and two binary32 patterns and returns one
// rounded result; a new transaction may enter in every cycle. The depth is set
// by the radix-2 divider, which develops one quotient bit per stage; add,
// subtract and multiply share the same pipeline so results leave in order.
// While a finished result waits for out_ready the whole pipeline holds and
// in_ready is low. NaN results are the canonical quiet NaN and a zero divisor
// gives +0.0 with divide_by_zero set.
module float_four_op_alu
  import fpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fpa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fpa_out_t out_data
);

  logic en;

  // The whole pipeline advances unless a finished result is held.
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  fpa_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_data  (in_data),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

endmodule

// ===== rtl/fpa_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_core: pipelined datapath of the float ALU.
// Stage 0 unpacks, then the add/multiply path and a radix-2 divider run side by
// side; the last stages normalize and round to nearest-even.
// ----------------------------------------------------------------------------
module fpa_core
  import fpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_vld,
  input  fpa_in_t  in_data,
  output logic     out_vld,
  output fpa_out_t out_data
);

  localparam int NST = QBITS + 4;

  // Per-stage state of one transaction.
  typedef struct packed {
    logic [1:0]  op;
    fpa_unp_t    a;
    fpa_unp_t    b;
    logic        special;
    logic [31:0] special_bits;
    logic        dz;
    logic [47:0] prod;
    logic [26:0] rem;
    logic [QBITS-1:0] quo;
  } stg_t;

  stg_t      s_r [NST];
  logic      v_r [NST];
  fpa_raw_t  raw_r;
  logic      raw_v_r;
  fpa_out_t  res_r;
  logic      res_v_r;

  // ---- stage 0: unpack and classify --------------------------------------
  stg_t s0_nxt;
  fpa_unp_t ua, ub;
  logic     bs;
  always_comb begin
    ua = unpack(in_data.operand_a);
    ub = unpack(in_data.operand_b);
    bs = ub.sgn ^ (in_data.opcode == OP_SUB);
    ub.sgn = bs;
    s0_nxt = '0;
    s0_nxt.op = in_data.opcode;
    s0_nxt.a  = ua;
    s0_nxt.b  = ub;
    s0_nxt.special_bits = CANON_NAN;
    unique case (fpa_op_t'(in_data.opcode))
      OP_ADD, OP_SUB: begin
        if (ua.nan || ub.nan || (ua.inf && ub.inf && ua.sgn != bs)) begin
          s0_nxt.special = 1'b1;
        end else if (ua.inf || ub.inf) begin
          s0_nxt.special = 1'b1;
          s0_nxt.special_bits = {ua.inf ? ua.sgn : bs, 8'hFF, 23'd0};
        end else if (ua.zero && ub.zero) begin
          s0_nxt.special = 1'b1;
          s0_nxt.special_bits = {ua.sgn & bs, 31'd0};
        end
      end
      OP_MUL: begin
        if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
          s0_nxt.special = 1'b1;
        end else if (ua.inf || ub.inf) begin
          s0_nxt.special = 1'b1;
          s0_nxt.special_bits = {ua.sgn ^ ub.sgn, 8'hFF, 23'd0};
        end else if (ua.zero || ub.zero) begin
          s0_nxt.special = 1'b1;
          s0_nxt.special_bits = {ua.sgn ^ ub.sgn, 31'd0};
        end
      end
      OP_DIV: begin
        if (ub.zero) begin
          s0_nxt.special = 1'b1;
          s0_nxt.dz = 1'b1;
          s0_nxt.special_bits = POS_ZERO;
        end else if (ua.nan || ub.nan || (ua.inf && ub.inf)) begin
          s0_nxt.special = 1'b1;
        end else if (ua.inf) begin
          s0_nxt.special = 1'b1;
          s0_nxt.special_bits = {ua.sgn ^ ub.sgn, 8'hFF, 23'd0};
        end else if (ua.zero || ub.inf) begin
          s0_nxt.special = 1'b1;
          s0_nxt.special_bits = {ua.sgn ^ ub.sgn, 31'd0};
        end
      end
      default: ;
    endcase
    s0_nxt.rem = {3'd0, ua.man};
  end

  // ---- middle stages: multiply in stage 1, one quotient bit per stage -----
  stg_t mid_nxt [NST];
  always_comb begin
    mid_nxt[0] = s0_nxt;
    for (int k = 1; k < NST; k++) begin
      logic [26:0] d;
      logic [26:0] tr;
      d  = {3'd0, s_r[k-1].b.man};
      tr = s_r[k-1].rem - d;
      mid_nxt[k] = s_r[k-1];
      if (k == 1) begin
        mid_nxt[k].prod = s_r[k-1].a.man * s_r[k-1].b.man;
      end
      if (k >= 2 && k < QBITS + 2) begin
        if (s_r[k-1].rem >= d) begin
          mid_nxt[k].rem = {tr[25:0], 1'b0};
          mid_nxt[k].quo = {s_r[k-1].quo[QBITS-2:0], 1'b1};
        end else begin
          mid_nxt[k].rem = {s_r[k-1].rem[25:0], 1'b0};
          mid_nxt[k].quo = {s_r[k-1].quo[QBITS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) s_r[k] <= mid_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
      for (int k = 1; k < NST; k++) v_r[k] <= v_r[k-1];
    end
  end

  // ---- form the unrounded result -----------------------------------------
  stg_t     sl;
  fpa_raw_t raw_nxt;
  logic [4:0]  sh;
  logic [27:0] big, sml, sum;
  logic        stk;
  logic signed [11:0] ed;
  always_comb begin
    sl = s_r[NST-1];
    raw_nxt = '0;
    raw_nxt.special = sl.special;
    raw_nxt.special_bits = sl.special_bits;
    raw_nxt.dz = sl.dz;
    big = '0; sml = '0; sum = '0; stk = 1'b0; ed = '0; sh = '0;
    case (fpa_op_t'(sl.op))
      OP_MUL: begin
        raw_nxt.sgn = sl.a.sgn ^ sl.b.sgn;
        // prod has leading one at bit 46 or 47; keep 28 bits plus sticky.
        raw_nxt.man = sl.prod[47:20];
        raw_nxt.sticky = |sl.prod[19:0];
        raw_nxt.exp = 12'(sl.a.exp) + 12'(sl.b.exp);
      end
      OP_DIV: begin
        raw_nxt.sgn = sl.a.sgn ^ sl.b.sgn;
        raw_nxt.man = {2'd0, sl.quo};
        raw_nxt.sticky = |sl.rem;
        raw_nxt.exp = 12'(sl.a.exp) - 12'(sl.b.exp) + 12'sd1;
      end
      default: begin
        // Align to the larger exponent; 3 guard bits below the mantissa.
        if (sl.b.zero || (!sl.a.zero && (sl.a.exp > sl.b.exp ||
            (sl.a.exp == sl.b.exp && sl.a.man >= sl.b.man)))) begin
          big = {1'b0, sl.a.man, 3'd0};
          sml = sl.b.zero ? 28'd0 : {1'b0, sl.b.man, 3'd0};
          ed  = 12'(sl.a.exp) - 12'(sl.b.exp);
          raw_nxt.sgn = sl.a.sgn;
          raw_nxt.exp = 12'(sl.a.exp);
        end else begin
          big = {1'b0, sl.b.man, 3'd0};
          sml = sl.a.zero ? 28'd0 : {1'b0, sl.a.man, 3'd0};
          ed  = 12'(sl.b.exp) - 12'(sl.a.exp);
          raw_nxt.sgn = sl.b.sgn;
          raw_nxt.exp = 12'(sl.b.exp);
        end
        if (ed > 12'sd27) begin
          stk = |sml;
          sml = '0;
        end else begin
          sh  = 5'(ed);
          stk = |(sml & ((28'd1 << sh) - 28'd1));
          sml = sml >> sh;
        end
        if (sl.a.sgn == sl.b.sgn) sum = big + sml;
        else sum = big - sml - 28'(stk);
        if (sum == 28'd0 && !stk) begin
          raw_nxt.special = ~sl.special;
          raw_nxt.special_bits = sl.special ? sl.special_bits : POS_ZERO;
          if (sl.special) raw_nxt.special = 1'b1;
        end
        raw_nxt.man = sum;
        raw_nxt.sticky = stk;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) raw_r <= raw_nxt;
  end

  // ---- normalize and round to nearest-even -------------------------------
  // Value = man * 2^(exp-26). Shift so the leading one sits at bit 27.
  fpa_out_t    res_nxt;
  logic [4:0]  rlz;
  logic signed [12:0] e;
  logic [54:0] ext;
  logic [54:0] shd;
  logic [12:0] rs;
  logic [23:0] m;
  logic        g, st, rup;
  logic [24:0] mr;
  logic [8:0]  be;
  always_comb begin
    rlz = clz28(raw_r.man);
    e   = 13'(raw_r.exp) + 13'sd1 - 13'(rlz);
    ext = {raw_r.man << rlz, 27'd0};
    rs  = '0;
    // Subnormal: exponent below -126 shifts right further.
    if (e < -13'sd126) begin
      rs = 13'(-13'sd126 - e);
      if (rs > 13'd30) rs = 13'd30;
      shd = ext >> rs[4:0];
      st  = raw_r.sticky | (|(ext & ((55'd1 << rs[4:0]) - 55'd1)));
      e   = -13'sd127;
    end else begin
      shd = ext;
      st  = raw_r.sticky;
    end
    // shd[54]: implicit bit position of the 28-bit field (bit 27 after shift).
    m   = shd[54:31];
    g   = shd[30];
    st  = st | (|shd[29:0]);
    rup = g && (st || m[0]);
    mr  = {1'b0, m} + 25'(rup);
    res_nxt.divide_by_zero = raw_r.dz;
    if (mr[24]) begin
      mr = mr >> 1;
      e  = e + 13'sd1;
    end else if (e == -13'sd127 && mr[23]) begin
      e = -13'sd126;
    end
    be = 9'(e + 13'sd127);
    if (e > 13'sd127) res_nxt.result_bits = {raw_r.sgn, 8'hFF, 23'd0};
    else if (e == -13'sd127 || !mr[23])
      res_nxt.result_bits = {raw_r.sgn, 8'd0, mr[22:0]};
    else res_nxt.result_bits = {raw_r.sgn, be[7:0], mr[22:0]};
    if (raw_r.special) res_nxt.result_bits = raw_r.special_bits;
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_v_r <= 1'b0;
      res_v_r <= 1'b0;
    end else if (en) begin
      raw_v_r <= v_r[NST-1];
      res_v_r <= raw_v_r;
    end
  end

  assign out_vld  = res_v_r;
  assign out_data = res_r;

  // Divide-by-zero only ever leaves with a +0.0 result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_data.divide_by_zero |-> out_data.result_bits == POS_ZERO)
    else $error("divide-by-zero result not +0.0");
  // A held pipeline keeps its output.
  assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_vld))
    else $error("output valid moved during stall");
  // The flag comes only from a divide.
  assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[NST-1] && s_r[NST-1].dz |-> s_r[NST-1].op == OP_DIV)
    else $error("flag on non-divide");

endmodule
